// ----- rtl/core/trf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trail ring package
// Shared types and constants of the trail ring buffer with fade.
// ----------------------------------------------------------------------------
package trf_pkg;

  localparam int RING_DEPTH_DEF = 32;
  localparam int CFG_DATA_W     = 16;

  // Function codes of an input word.
  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_TICK = 2'd1,
    OP_DRAW = 2'd2
  } op_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_RING_SIZE    = 2'd0;
  localparam logic [1:0] REG_TEXTURED     = 2'd1;
  localparam logic [1:0] REG_GLOBAL_ALPHA = 2'd2;
  localparam logic [1:0] REG_TEX_STEP     = 2'd3;

  localparam logic [5:0]  RING_SIZE_RST    = 6'd32;
  localparam logic [7:0]  GLOBAL_ALPHA_RST = 8'd255;
  localparam logic [16:0] FULL_LIFE        = 17'h10000;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] first_x;
    logic [31:0] first_y;
    logic [31:0] first_z;
    logic [31:0] second_x;
    logic [31:0] second_y;
    logic [31:0] second_z;
    logic [31:0] first_rgba;
    logic [31:0] second_rgba;
    logic [16:0] decay;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [31:0] out_rgba;
    logic [21:0] tex_s;
    logic        vertex_side;
    logic [5:0]  live_count;
    logic        last;
  } out_word_t;

  // One stored segment, as held in the segment memory.
  typedef struct packed {
    logic [31:0] first_x;
    logic [31:0] first_y;
    logic [31:0] first_z;
    logic [31:0] second_x;
    logic [31:0] second_y;
    logic [31:0] second_z;
    logic [31:0] first_rgba;
    logic [31:0] second_rgba;
  } seg_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_t         op;
    seg_t        seg;
    logic [16:0] decay;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  ring_size;
    logic        textured_mode;
    logic [7:0]  global_alpha;
    logic [15:0] tex_step;
  } cfg_t;

endpackage

// ----- rtl/core/trail_ring_buffer_with_fade_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trail ring buffer with fade
// Ring of trail segments with lifetime decay and faded vertex output.
// ----------------------------------------------------------------------------
// Usage. Input words enter through push/full and carry a function code:
// add stores a segment at the head, tick decays every live segment and
// returns one status word, draw returns two vertex words per live segment
// (newest first in plain mode, oldest first with texture coordinate in
// textured mode). Results leave through empty/pop in order; the final word
// of each command has last set. Configuration is written through
// cfg_valid/cfg_ready (always ready); the user must write it only while
// the block is idle, which the block itself does not enforce; after
// changing ring_size the block should be reset. An add is done in the
// back end's idle state. A tick reads and writes back each live segment's
// lifetime, then emits its status word. A draw passes each live segment
// through the memory read and two-stage alpha multiply. A command queue
// of two words lets input be taken while the back end works, and a
// two-word result queue decouples the back end from the receiver: when
// the receiver stops popping the back end holds and then the input side
// fills. Reset clears the head, the live count and both queues; the
// segment memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module trail_ring_buffer_with_fade_unit #(
  parameter int RING_DEPTH = trf_pkg::RING_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  trf_pkg::in_word_t                 item,
  output logic                              full,
  output logic                              empty,
  input  logic                              pop,
  output trf_pkg::out_word_t                result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [trf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  trf_pkg::cfg_t cfg;
  trf_pkg::cmd_t cmd;
  logic          cmd_empty;
  logic          cmd_pop;

  // Registers accept a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ring_size     <= trf_pkg::RING_SIZE_RST;
      cfg.textured_mode <= 1'b0;
      cfg.global_alpha  <= trf_pkg::GLOBAL_ALPHA_RST;
      cfg.tex_step      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        trf_pkg::REG_RING_SIZE:    cfg.ring_size     <= cfg_data[5:0];
        trf_pkg::REG_TEXTURED:     cfg.textured_mode <= cfg_data[0];
        trf_pkg::REG_GLOBAL_ALPHA: cfg.global_alpha  <= cfg_data[7:0];
        trf_pkg::REG_TEX_STEP:     cfg.tex_step      <= cfg_data[15:0];
        default: begin
          cfg.tex_step <= cfg.tex_step;
        end
      endcase
    end
  end

  // The front classifies and queues commands; unknown functions are dropped.
  trf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .cmd_empty(cmd_empty)
  );

  // The back end owns the segment memories and the result queue.
  trf_back #(
    .RING_DEPTH(RING_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

// ----- rtl/core/trf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module trf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/trf_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small queue
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module trf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop_ok) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(push_ok) - CW'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ----- rtl/core/trf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trail ring front end
// Accepts input words, classifies the function and queues commands.
// ----------------------------------------------------------------------------
module trf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  trf_pkg::in_word_t item,
  output logic              full,
  input  logic              cmd_pop,
  output trf_pkg::cmd_t     cmd,
  output logic              cmd_empty
);

  trf_pkg::cmd_t cmd_in;
  logic          known;

  // An unknown function has no effect at all, so it is taken and dropped.
  assign known = (item.func == trf_pkg::OP_ADD) || (item.func == trf_pkg::OP_TICK) ||
                 (item.func == trf_pkg::OP_DRAW);

  always_comb begin
    cmd_in.op               = trf_pkg::op_t'(item.func);
    cmd_in.seg.first_x      = item.first_x;
    cmd_in.seg.first_y      = item.first_y;
    cmd_in.seg.first_z      = item.first_z;
    cmd_in.seg.second_x     = item.second_x;
    cmd_in.seg.second_y     = item.second_y;
    cmd_in.seg.second_z     = item.second_z;
    cmd_in.seg.first_rgba   = item.first_rgba;
    cmd_in.seg.second_rgba  = item.second_rgba;
    cmd_in.decay            = item.decay;
  end

  trf_fifo #(
    .WIDTH($bits(trf_pkg::cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push && known),
    .wdata(cmd_in),
    .full (full),
    .pop  (cmd_pop),
    .rdata(cmd),
    .empty(cmd_empty)
  );

endmodule

// ----- rtl/core/trf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trail ring back end
// Executes add, tick and draw commands against the segment memories.
// ----------------------------------------------------------------------------
module trf_back #(
  parameter int RING_DEPTH = trf_pkg::RING_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  trf_pkg::cfg_t      cfg,
  input  trf_pkg::cmd_t      cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output trf_pkg::out_word_t result,
  output logic               empty,
  input  logic               pop
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_TRD  = 9'b000000010,
    ST_TWR  = 9'b000000100,
    ST_TST  = 9'b000001000,
    ST_DRD  = 9'b000010000,
    ST_DM1  = 9'b000100000,
    ST_DM2  = 9'b001000000,
    ST_DE0  = 9'b010000000,
    ST_DE1  = 9'b100000000
  } state_t;

  state_t      state;
  logic [AW-1:0] head;
  logic [CW-1:0] live;
  logic [CW-1:0] n_r;
  logic [AW-1:0] j;
  logic [CW-1:0] remaining;
  logic [CW-1:0] left;
  logic [16:0]   decay;
  logic [21:0]   s;
  logic [15:0]   m1_0;
  logic [15:0]   m1_1;
  logic [16:0]   m2_0;
  logic [16:0]   m2_1;

  logic [CW-1:0] n_c;
  logic [AW-1:0] head_c;
  logic [CW-1:0] cnt_c;
  logic [AW-1:0] start_c;
  logic [AW-1:0] j_next;

  trf_pkg::seg_t seg_rdata;
  logic [16:0]   life_rdata;
  logic          seg_we;
  logic          life_we;
  logic [AW-1:0] life_waddr;
  logic [16:0]   life_wdata;

  trf_pkg::out_word_t word;
  logic          out_push;
  logic          out_full;

  function automatic logic [AW-1:0] prev_idx(input logic [AW-1:0] idx,
                                             input logic [CW-1:0] n);
    prev_idx = (idx == '0) ? AW'(n - 1'b1) : idx - 1'b1;
  endfunction

  // Alpha from the second product: textured mode divides by 255 through the
  // usual add-and-shift form, which is exact for values below 65536.
  function automatic logic [7:0] alpha_of(input logic [16:0] v, input logic tex);
    logic [16:0] q;
    q = tex ? ((v + 17'd1 + (v >> 8)) >> 8) : v;
    alpha_of = (q > 17'd255) ? 8'd255 : q[7:0];
  endfunction

  // Effective ring size, head and count, oldest slot and next draw slot.
  always_comb begin
    if (cfg.ring_size == '0) begin
      n_c = CW'(1);
    end else if (cfg.ring_size > 6'(RING_DEPTH)) begin
      n_c = CW'(RING_DEPTH);
    end else begin
      n_c = CW'(cfg.ring_size);
    end
    head_c  = (CW'(head) < n_c) ? head : '0;
    cnt_c   = (live > n_c) ? n_c : live;
    start_c = (CW'(head_c) >= cnt_c) ? AW'(CW'(head_c) - cnt_c)
                                     : AW'(CW'(head_c) + n_c - cnt_c);
    if (cfg.textured_mode) begin
      j_next = (CW'(j) + 1'b1 >= n_r) ? '0 : j + 1'b1;
    end else begin
      j_next = prev_idx(j, n_r);
    end
  end

  assign cmd_pop = (state == ST_IDLE) && !cmd_empty;
  assign seg_we  = cmd_pop && (cmd.op == trf_pkg::OP_ADD);

  always_comb begin
    life_we    = 1'b0;
    life_waddr = j;
    life_wdata = '0;
    if (seg_we) begin
      life_we    = 1'b1;
      life_waddr = head_c;
      life_wdata = trf_pkg::FULL_LIFE;
    end else if (state == ST_TWR) begin
      life_we    = 1'b1;
      life_wdata = (life_rdata <= decay) ? '0 : life_rdata - decay;
    end
  end

  trf_ram #(
    .WIDTH($bits(trf_pkg::seg_t)),
    .DEPTH(RING_DEPTH)
  ) u_seg_ram (
    .clk  (clk),
    .we   (seg_we),
    .waddr(head_c),
    .wdata(cmd.seg),
    .raddr(j),
    .rdata(seg_rdata)
  );

  trf_ram #(
    .WIDTH(17),
    .DEPTH(RING_DEPTH)
  ) u_life_ram (
    .clk  (clk),
    .we   (life_we),
    .waddr(life_waddr),
    .wdata(life_wdata),
    .raddr(j),
    .rdata(life_rdata)
  );

  // Result word under construction.
  always_comb begin
    word     = '0;
    out_push = 1'b0;
    case (state)
      ST_TST: begin
        out_push        = 1'b1;
        word.kind       = 1'b1;
        word.live_count = 6'(left);
        word.last       = 1'b1;
      end
      ST_DE0: begin
        out_push        = 1'b1;
        word.out_x      = seg_rdata.first_x;
        word.out_y      = seg_rdata.first_y;
        word.out_z      = seg_rdata.first_z;
        word.out_rgba   = {seg_rdata.first_rgba[31:8], alpha_of(m2_0, cfg.textured_mode)};
        word.tex_s      = cfg.textured_mode ? s : '0;
        word.live_count = 6'(live);
      end
      ST_DE1: begin
        out_push         = 1'b1;
        word.out_x       = seg_rdata.second_x;
        word.out_y       = seg_rdata.second_y;
        word.out_z       = seg_rdata.second_z;
        word.out_rgba    = {seg_rdata.second_rgba[31:8], alpha_of(m2_1, cfg.textured_mode)};
        word.tex_s       = cfg.textured_mode ? s : '0;
        word.vertex_side = 1'b1;
        word.live_count  = 6'(live);
        word.last        = (remaining == CW'(1));
      end
      default: begin
        out_push = 1'b0;
      end
    endcase
  end

  trf_fifo #(
    .WIDTH($bits(trf_pkg::out_word_t)),
    .DEPTH(2)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .wdata(word),
    .full (out_full),
    .pop  (pop),
    .rdata(result),
    .empty(empty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      live      <= '0;
      n_r       <= CW'(1);
      j         <= '0;
      remaining <= '0;
      left      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            n_r <= n_c;
            case (cmd.op)
              trf_pkg::OP_ADD: begin
                head <= (CW'(head_c) + 1'b1 >= n_c) ? '0 : head_c + 1'b1;
                live <= (cnt_c < n_c) ? cnt_c + 1'b1 : cnt_c;
              end
              trf_pkg::OP_TICK: begin
                head      <= head_c;
                live      <= cnt_c;
                remaining <= cnt_c;
                left      <= cnt_c;
                j         <= prev_idx(head_c, n_c);
                state     <= (cnt_c == '0) ? ST_TST : ST_TRD;
              end
              trf_pkg::OP_DRAW: begin
                head      <= head_c;
                live      <= cnt_c;
                remaining <= cnt_c;
                j         <= cfg.textured_mode ? start_c : prev_idx(head_c, n_c);
                if (cnt_c != '0) begin
                  state <= ST_DRD;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_TRD: begin
          state <= ST_TWR;
        end
        ST_TWR: begin
          if (life_rdata <= decay) begin
            left <= left - 1'b1;
          end
          if (remaining == CW'(1)) begin
            state <= ST_TST;
          end else begin
            remaining <= remaining - 1'b1;
            j         <= prev_idx(j, n_r);
            state     <= ST_TRD;
          end
        end
        ST_TST: begin
          if (!out_full) begin
            live <= left;
            if (left == '0 && live != '0) begin
              head <= '0;
            end
            state <= ST_IDLE;
          end
        end
        ST_DRD: begin
          state <= ST_DM1;
        end
        ST_DM1: begin
          state <= ST_DM2;
        end
        ST_DM2: begin
          state <= ST_DE0;
        end
        ST_DE0: begin
          if (!out_full) begin
            state <= ST_DE1;
          end
        end
        ST_DE1: begin
          if (!out_full) begin
            if (remaining == CW'(1)) begin
              state <= ST_IDLE;
            end else begin
              remaining <= remaining - 1'b1;
              j         <= j_next;
              state     <= ST_DRD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      decay <= cmd.decay;
      s     <= 22'(cfg.tex_step * start_c);
    end
    if (state == ST_DE1 && !out_full) begin
      s <= 22'(s + cfg.tex_step);
    end
    if (state == ST_DM1) begin
      m1_0 <= 16'(seg_rdata.first_rgba[7:0]) *
              16'(cfg.textured_mode ? cfg.global_alpha : 8'd1);
      m1_1 <= 16'(seg_rdata.second_rgba[7:0]) *
              16'(cfg.textured_mode ? cfg.global_alpha : 8'd1);
    end
    if (state == ST_DM2) begin
      m2_0 <= 17'((33'(m1_0) * 33'(life_rdata)) >> 16);
      m2_1 <= 17'((33'(m1_1) * 33'(life_rdata)) >> 16);
    end
  end

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= CW'(RING_DEPTH))
    else $error("live count above ring depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (out_push && out_full) |=> $stable(state))
    else $error("back end advanced while the result queue was full");

  a_walk_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TWR || state == ST_DE1) |-> remaining != '0)
    else $error("slot walk with no slots remaining");

  a_tick_left: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TST) |-> left <= live)
    else $error("tick left more segments than were live");
`endif

endmodule
